### rtl/packed_pixel_format_unpacker_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the packed pixel format unpacker
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_FORMAT_UNPACKER_UNIT_ASSERT_SVH
`define PACKED_PIXEL_FORMAT_UNPACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PPFU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppfu same-cycle check failed");

// next-cycle implication, disabled during reset
`define PPFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppfu next-cycle check failed");

`endif

### rtl/ppfu_pkg.sv
// ----------------------------------------------------------------------------
// ppfu_pkg
// shared types, format codes and component expansion functions
// ----------------------------------------------------------------------------
package ppfu_pkg;

   localparam int unsigned FMT_W = 4;

   // pixel format codes
   localparam logic [FMT_W-1:0] FMT_RGBA8888_WORD = 4'd0;
   localparam logic [FMT_W-1:0] FMT_RGB_BYTES     = 4'd1;
   localparam logic [FMT_W-1:0] FMT_RGBA_BYTES    = 4'd2;
   localparam logic [FMT_W-1:0] FMT_GRAY8         = 4'd3;
   localparam logic [FMT_W-1:0] FMT_RED8          = 4'd4;
   localparam logic [FMT_W-1:0] FMT_GREEN8        = 4'd5;
   localparam logic [FMT_W-1:0] FMT_BLUE8         = 4'd6;
   localparam logic [FMT_W-1:0] FMT_RGBA4444      = 4'd7;
   localparam logic [FMT_W-1:0] FMT_RGBA5551      = 4'd8;
   localparam logic [FMT_W-1:0] FMT_RGB332        = 4'd9;
   localparam logic [FMT_W-1:0] FMT_GRAY16        = 4'd10;
   localparam logic [FMT_W-1:0] FMT_RED16         = 4'd11;
   localparam logic [FMT_W-1:0] FMT_GREEN16       = 4'd12;
   localparam logic [FMT_W-1:0] FMT_BLUE16        = 4'd13;

   // register indexes
   localparam logic REG_PIXEL_FORMAT = 1'b0;

   localparam logic [15:0] FULL_SCALE = 16'hFFFF;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        alpha_present;
   } pix_result_type;

   // code * 65535 / 255 is exact: byte replicated
   function automatic logic [15:0] scale8(input logic [7:0] c);
      return {c, c};
   endfunction

   // code * 65535 / 15 is exact: nibble replicated
   function automatic logic [15:0] scale4(input logic [3:0] c);
      return {c, c, c, c};
   endfunction

   // 65535 = 31 * 2114 + 1, rounding adds one from code 16 up
   function automatic logic [15:0] scale5(input logic [4:0] c);
      return 16'({11'd0, c} * 16'd2114) + {15'd0, c[4]};
   endfunction

   // 65535 = 7 * 9362 + 1, rounding adds one from code 4 up
   function automatic logic [15:0] scale3(input logic [2:0] c);
      return 16'({13'd0, c} * 16'd9362) + {15'd0, c[2]};
   endfunction

   // code * 65535 / 3 is exact: two bits replicated
   function automatic logic [15:0] scale2(input logic [1:0] c);
      return {8{c}};
   endfunction

   // single bit gives zero or full scale
   function automatic logic [15:0] scale1(input logic c);
      return {16{c}};
   endfunction

endpackage

### rtl/ppfu_csr.sv
// ----------------------------------------------------------------------------
// ppfu_csr
// apb-style register file holding the pixel format
// ----------------------------------------------------------------------------
module ppfu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic [ppfu_pkg::FMT_W-1:0]  pixel_format
);

   logic                       wr_en;
   logic [ppfu_pkg::FMT_W-1:0] fmt_ff;
   logic [ppfu_pkg::FMT_W-1:0] fmt_in;

   // write beat completes in the access phase
   assign wr_en = psel && penable && pwrite && (paddr[2] == ppfu_pkg::REG_PIXEL_FORMAT);

   assign fmt_in = wr_en ? pwdata[ppfu_pkg::FMT_W-1:0] : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= ppfu_pkg::FMT_RGBA8888_WORD;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   // read back
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == ppfu_pkg::REG_PIXEL_FORMAT) begin
         prdata = {{(32-ppfu_pkg::FMT_W){1'b0}}, fmt_ff};
      end
   end

   assign pixel_format = fmt_ff;

endmodule

### rtl/ppfu_convert.sv
// ----------------------------------------------------------------------------
// ppfu_convert
// unpacks one pixel word into normalized rgba under a given format
// ----------------------------------------------------------------------------
module ppfu_convert (
   input  logic [31:0]                 pixel_word,
   input  logic [ppfu_pkg::FMT_W-1:0]  pixel_format,
   output ppfu_pkg::pix_result_type    result
);

   logic [15:0] v8;
   logic [15:0] v16;

   assign v8  = ppfu_pkg::scale8(pixel_word[7:0]);
   assign v16 = pixel_word[15:0];

   // per-format field selection and expansion
   always_comb begin
      result.red           = 16'd0;
      result.green         = 16'd0;
      result.blue          = 16'd0;
      result.alpha         = ppfu_pkg::FULL_SCALE;
      result.alpha_present = 1'b0;
      unique case (pixel_format)
         ppfu_pkg::FMT_RGBA8888_WORD, ppfu_pkg::FMT_RGBA_BYTES: begin
            result.red           = ppfu_pkg::scale8(pixel_word[31:24]);
            result.green         = ppfu_pkg::scale8(pixel_word[23:16]);
            result.blue          = ppfu_pkg::scale8(pixel_word[15:8]);
            result.alpha         = ppfu_pkg::scale8(pixel_word[7:0]);
            result.alpha_present = 1'b1;
         end
         ppfu_pkg::FMT_RGB_BYTES: begin
            result.red   = ppfu_pkg::scale8(pixel_word[23:16]);
            result.green = ppfu_pkg::scale8(pixel_word[15:8]);
            result.blue  = ppfu_pkg::scale8(pixel_word[7:0]);
         end
         ppfu_pkg::FMT_GRAY8: begin
            result.red   = v8;
            result.green = v8;
            result.blue  = v8;
         end
         ppfu_pkg::FMT_RED8: begin
            result.red = v8;
         end
         ppfu_pkg::FMT_GREEN8: begin
            result.green = v8;
         end
         ppfu_pkg::FMT_BLUE8: begin
            result.blue = v8;
         end
         ppfu_pkg::FMT_RGBA4444: begin
            result.red           = ppfu_pkg::scale4(pixel_word[15:12]);
            result.green         = ppfu_pkg::scale4(pixel_word[11:8]);
            result.blue          = ppfu_pkg::scale4(pixel_word[7:4]);
            result.alpha         = ppfu_pkg::scale4(pixel_word[3:0]);
            result.alpha_present = 1'b1;
         end
         ppfu_pkg::FMT_RGBA5551: begin
            result.red           = ppfu_pkg::scale5(pixel_word[15:11]);
            result.green         = ppfu_pkg::scale5(pixel_word[10:6]);
            result.blue          = ppfu_pkg::scale5(pixel_word[5:1]);
            result.alpha         = ppfu_pkg::scale1(pixel_word[0]);
            result.alpha_present = 1'b1;
         end
         ppfu_pkg::FMT_RGB332: begin
            result.red   = ppfu_pkg::scale3(pixel_word[7:5]);
            result.green = ppfu_pkg::scale3(pixel_word[4:2]);
            result.blue  = ppfu_pkg::scale2(pixel_word[1:0]);
         end
         ppfu_pkg::FMT_GRAY16: begin
            result.red   = v16;
            result.green = v16;
            result.blue  = v16;
         end
         ppfu_pkg::FMT_RED16: begin
            result.red = v16;
         end
         ppfu_pkg::FMT_GREEN16: begin
            result.green = v16;
         end
         ppfu_pkg::FMT_BLUE16: begin
            result.blue = v16;
         end
         // undefined codes: black, opaque, no alpha
         default: begin
            result.red = 16'd0;
         end
      endcase
   end

endmodule

### rtl/packed_pixel_format_unpacker_unit.sv
// ----------------------------------------------------------------------------
// packed_pixel_format_unpacker_unit: packed pixel word to normalized rgba
// the start beat passes the input register, then the result register, to the rsp_valid strobe
// throughput one pixel per cycle, busy stays low, set by the input register
// sync reset clears the pipeline valids and the format to rgba8888 word
// ----------------------------------------------------------------------------
`include "packed_pixel_format_unpacker_unit_assert.svh"

module packed_pixel_format_unpacker_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pixel_word,
   // result channel
   output logic        rsp_valid,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out,
   output logic [15:0] rsp_alpha_out,
   output logic        rsp_alpha_present,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [ppfu_pkg::FMT_W-1:0] cfg_format;
   logic                       in_beat;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic [31:0]                s1_word_ff;
   logic [31:0]                s1_word_in;
   logic [ppfu_pkg::FMT_W-1:0] s1_fmt_ff;
   logic [ppfu_pkg::FMT_W-1:0] s1_fmt_in;

   ppfu_pkg::pix_result_type   conv_result;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   ppfu_pkg::pix_result_type   out_res_ff;
   ppfu_pkg::pix_result_type   out_res_in;

   // register file
   ppfu_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pixel_format (cfg_format)
   );

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign in_beat = start && !busy;

   // input register
   assign s1_valid_in = in_beat;
   assign s1_word_in  = in_beat ? req_pixel_word : s1_word_ff;
   assign s1_fmt_in   = in_beat ? cfg_format : s1_fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_word_ff <= s1_word_in;
      s1_fmt_ff  <= s1_fmt_in;
   end

   // conversion logic
   ppfu_convert u_convert (
      .pixel_word   (s1_word_ff),
      .pixel_format (s1_fmt_ff),
      .result       (conv_result)
   );

   // result register
   assign out_valid_in = s1_valid_ff;
   assign out_res_in   = s1_valid_ff ? conv_result : out_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red_out       = out_res_ff.red;
   assign rsp_green_out     = out_res_ff.green;
   assign rsp_blue_out      = out_res_ff.blue;
   assign rsp_alpha_out     = out_res_ff.alpha;
   assign rsp_alpha_present = out_res_ff.alpha_present;

   // checks
   `PPFU_ASSERT_NEXT(a_beat_gives_result, clock, reset, in_beat, s1_valid_ff)
   `PPFU_ASSERT_NEXT(a_stage_gives_strobe, clock, reset, s1_valid_ff, rsp_valid)
   `PPFU_ASSERT_SAME(a_no_alpha_opaque, clock, reset, rsp_valid && !rsp_alpha_present,
      rsp_alpha_out == ppfu_pkg::FULL_SCALE)

endmodule
